// File: hw/rtl/zone_sensor_decoder_speedometer_defines.svh
// Assertion macros shared by the zone sensor decoder checker.
// Include in any file that asserts; needs nothing else.
`ifndef ZONE_SENSOR_DECODER_SPEEDOMETER_DEFINES_SVH
`define ZONE_SENSOR_DECODER_SPEEDOMETER_DEFINES_SVH

// Same-cycle implication, disabled while rst is high
`define ZSDS_ASSERT_SAME(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("zsds check failed");

// Next-cycle implication, disabled while rst is high
`define ZSDS_ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("zsds check failed");

`endif

// File: hw/rtl/zsds_pkg.sv
// Shared types and constants for the zone sensor decoder and speedometer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package zsds_pkg;

   // Delay line length in samples (range 2..64)
   localparam int WINDOW_DEPTH = 8;
   localparam int CHAIN_CELLS  = WINDOW_DEPTH - 1;

   localparam int GAIN_W      = 24;
   localparam int CSR_INDEX_W = 4;

   // Register indexes of the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_FRONT_GAIN = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BACK_GAIN  = 4'd1;

   // Step direction codes
   localparam logic [1:0] DIR_NONE = 2'd0;
   localparam logic [1:0] DIR_FWD  = 2'd1;
   localparam logic [1:0] DIR_BACK = 2'd2;

   // Zone windows, open bounds made inclusive
   localparam logic [9:0] ZONE0_MIN = 10'd951;   // 950..1050
   localparam logic [9:0] ZONE0_MAX = 10'd1023;  // upper bound lies past full scale
   localparam logic [9:0] ZONE1_MIN = 10'd501;   // 500..575
   localparam logic [9:0] ZONE1_MAX = 10'd574;
   localparam logic [9:0] ZONE2_MIN = 10'd301;   // 300..400
   localparam logic [9:0] ZONE2_MAX = 10'd399;
   localparam logic [9:0] ZONE3_MIN = 10'd701;   // 700..850
   localparam logic [9:0] ZONE3_MAX = 10'd849;

   typedef struct packed {
      logic        [9:0]  raw_sensor;
      logic signed [31:0] motor_degrees;
   } req_type;

   typedef struct packed {
      logic signed [31:0] tick_count;
      logic        [1:0]  step_dir;
      logic               bad_reading;
      logic signed [31:0] front_speed;
      logic signed [31:0] back_speed;
   } rsp_type;

   // Tracker results for the current sample
   typedef struct packed {
      logic signed [31:0] tick_count;
      logic        [1:0]  step_dir;
      logic               bad_reading;
   } trk_type;

   // One delay line entry: tick total and negated motor count
   typedef struct packed {
      logic [31:0] front;
      logic [31:0] back;
   } hist_type;

endpackage

`default_nettype wire

// File: hw/rtl/zsds_cell.sv
// One cell of the history delay chain; holds a front and a back sample.
// Depends on zsds_pkg.
`timescale 1ns / 1ps
`default_nettype none

module zsds_cell (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              shift_en,
   input  wire zsds_pkg::hist_type d,
   output zsds_pkg::hist_type      q
);

   zsds_pkg::hist_type hist_ff;

   // History starts at zero; shift by one sample per transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff <= '0;
      end else if (shift_en) begin
         hist_ff <= d;
      end
   end

   assign q = hist_ff;

endmodule

`default_nettype wire

// File: hw/rtl/zsds_tracker.sv
// Zone classification and tick counting state.
// Depends on zsds_pkg.
`timescale 1ns / 1ps
`default_nettype none

module zsds_tracker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        step_en,
   input  wire logic [9:0]  raw_sensor,
   output zsds_pkg::trk_type trk
);

   logic [1:0]  last_zone_ff, last_zone_in;
   logic [1:0]  second_zone_ff, second_zone_in;
   logic [31:0] tick_ff, tick_in;
   logic [1:0]  zone;
   logic        bad;
   logic [1:0]  dir;

   // Sort reading into a zone; out-of-window holds the previous zone
   always_comb begin
      bad  = 1'b0;
      zone = last_zone_ff;
      if (raw_sensor inside {[zsds_pkg::ZONE0_MIN:zsds_pkg::ZONE0_MAX]}) begin
         zone = 2'd0;
      end else if (raw_sensor inside {[zsds_pkg::ZONE1_MIN:zsds_pkg::ZONE1_MAX]}) begin
         zone = 2'd1;
      end else if (raw_sensor inside {[zsds_pkg::ZONE2_MIN:zsds_pkg::ZONE2_MAX]}) begin
         zone = 2'd2;
      end else if (raw_sensor inside {[zsds_pkg::ZONE3_MIN:zsds_pkg::ZONE3_MAX]}) begin
         zone = 2'd3;
      end else begin
         bad = 1'b1;
      end
   end

   // Count only when three zones step the same way
   always_comb begin
      tick_in        = tick_ff;
      second_zone_in = second_zone_ff;
      dir            = zsds_pkg::DIR_NONE;
      if (2'(zone + 2'd2) == second_zone_ff) begin
         if (2'(zone + 2'd1) == last_zone_ff) begin
            tick_in        = tick_ff + 32'd1;
            second_zone_in = last_zone_ff;
            dir            = zsds_pkg::DIR_FWD;
         end else if (2'(zone + 2'd3) == last_zone_ff) begin
            tick_in        = tick_ff - 32'd1;
            second_zone_in = last_zone_ff;
            dir            = zsds_pkg::DIR_BACK;
         end
      end
      last_zone_in = zone;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_zone_ff   <= '0;
         second_zone_ff <= '0;
         tick_ff        <= '0;
      end else if (step_en) begin
         last_zone_ff   <= last_zone_in;
         second_zone_ff <= second_zone_in;
         tick_ff        <= tick_in;
      end
   end

   assign trk.tick_count  = $signed(tick_in);
   assign trk.step_dir    = dir;
   assign trk.bad_reading = bad;

endmodule

`default_nettype wire

// File: hw/rtl/zsds_scaler.sv
// Gain multiply, round to nearest (ties up) by 2^16, saturate to 32 bits.
// Two register stages; depends on zsds_pkg.
`timescale 1ns / 1ps
`default_nettype none

module zsds_scaler (
   input  wire logic                         clock,
   input  wire logic                         mult_en,
   input  wire logic                         out_en,
   input  wire logic signed [32:0]           diff,
   input  wire logic [zsds_pkg::GAIN_W-1:0]  gain,
   output logic signed [31:0]                speed
);

   logic signed [zsds_pkg::GAIN_W:0] gain_s;
   logic signed [57:0] prod_ff, prod_in;
   logic signed [57:0] rounded;
   logic signed [41:0] quot;
   logic signed [31:0] speed_ff, speed_in;

   // Multiply stage
   assign gain_s  = $signed({1'b0, gain});
   assign prod_in = diff * gain_s;

   // Round and saturate stage; floor of (p + half) is the arithmetic shift
   always_comb begin
      rounded = prod_ff + 58'sd32768;
      quot    = 42'(rounded >>> 16);
      if (quot[41:31] == '0 || quot[41:31] == '1) begin
         speed_in = quot[31:0];
      end else if (quot[41]) begin
         speed_in = 32'sh8000_0000;
      end else begin
         speed_in = 32'sh7fff_ffff;
      end
   end

   always_ff @(posedge clock) begin
      if (mult_en) begin
         prod_ff <= prod_in;
      end
      if (out_en) begin
         speed_ff <= speed_in;
      end
   end

   assign speed = speed_ff;

endmodule

`default_nettype wire

// File: hw/rtl/zone_sensor_decoder_speedometer.sv
// Zone sensor decoder with front and back wheel speed from delay chains.
// Depends on zsds_pkg, zsds_tracker, zsds_cell, zsds_scaler.
//
//   channel  direction  payload             handshake
//   req_     in         zsds_pkg::req_type  req_valid / req_ready
//   rsp_     out        zsds_pkg::rsp_type  rsp_valid / rsp_ready
//   csr_     in         index + 24b data    csr_valid / csr_ready (always ready)
//
// One transaction per cycle sustained while rsp_ready does not stall; a result
// is valid after the difference, multiply and round/saturate stages.
// Each stage loads when it is empty or its successor moves on, so bubbles
// are squeezed out under a stalled rsp_ready.
// Synchronous reset clears zones, tick total, delay chain and gains.
`timescale 1ns / 1ps
`default_nettype none

module zone_sensor_decoder_speedometer (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire zsds_pkg::req_type                 req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output zsds_pkg::rsp_type                      rsp_data,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [zsds_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [zsds_pkg::GAIN_W-1:0]       csr_data
);

   logic [zsds_pkg::GAIN_W-1:0] front_gain_ff, back_gain_ff;

   logic               accept;
   logic               rdy1, rdy2, rdy3;
   logic               v1_ff, v2_ff, rsp_valid_ff;
   zsds_pkg::trk_type  trk;
   zsds_pkg::hist_type newest, oldest;
   zsds_pkg::hist_type chain_d [zsds_pkg::CHAIN_CELLS];
   zsds_pkg::hist_type chain_q [zsds_pkg::CHAIN_CELLS];

   zsds_pkg::trk_type  s1_ff, s2_ff, s3_ff;
   logic signed [32:0] front_diff_ff, front_diff_in;
   logic signed [32:0] back_diff_ff, back_diff_in;
   logic signed [31:0] front_speed, back_speed;

   // Stage flow control
   assign rdy3      = !rsp_valid_ff || rsp_ready;
   assign rdy2      = !v2_ff || rdy3;
   assign rdy1      = !v1_ff || rdy2;
   assign req_ready = rdy1;
   assign accept    = req_valid && rdy1;

   // Configuration registers
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         front_gain_ff <= '0;
         back_gain_ff  <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            zsds_pkg::CSR_FRONT_GAIN: front_gain_ff <= csr_data;
            zsds_pkg::CSR_BACK_GAIN:  back_gain_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // Zone and tick tracking
   zsds_tracker u_tracker (
      .clock      (clock),
      .reset      (reset),
      .step_en    (accept),
      .raw_sensor (req_data.raw_sensor),
      .trk        (trk)
   );

   // History chain: cell k holds the sample from k+1 transactions back
   assign newest.front = trk.tick_count;
   assign newest.back  = 32'd0 - req_data.motor_degrees;

   for (genvar k = 0; k < zsds_pkg::CHAIN_CELLS; k++) begin : g_chain
      if (k == 0) begin : g_head
         assign chain_d[k] = newest;
      end else begin : g_body
         assign chain_d[k] = chain_q[k-1];
      end
      zsds_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (accept),
         .d        (chain_d[k]),
         .q        (chain_q[k])
      );
   end

   assign oldest = chain_q[zsds_pkg::CHAIN_CELLS-1];

   // Stage 1: newest minus oldest
   assign front_diff_in = $signed({newest.front[31], newest.front})
                        - $signed({oldest.front[31], oldest.front});
   assign back_diff_in  = $signed({newest.back[31], newest.back})
                        - $signed({oldest.back[31], oldest.back});

   always_ff @(posedge clock) begin
      if (rdy1) begin
         s1_ff         <= trk;
         front_diff_ff <= front_diff_in;
         back_diff_ff  <= back_diff_in;
      end
      if (rdy2) begin
         s2_ff <= s1_ff;
      end
      if (rdy3) begin
         s3_ff <= s2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rdy1) begin
            v1_ff <= req_valid;
         end
         if (rdy2) begin
            v2_ff <= v1_ff;
         end
         if (rdy3) begin
            rsp_valid_ff <= v2_ff;
         end
      end
   end

   // Stages 2 and 3: scale each difference by its gain
   zsds_scaler u_front_scaler (
      .clock   (clock),
      .mult_en (rdy2),
      .out_en  (rdy3),
      .diff    (front_diff_ff),
      .gain    (front_gain_ff),
      .speed   (front_speed)
   );

   zsds_scaler u_back_scaler (
      .clock   (clock),
      .mult_en (rdy2),
      .out_en  (rdy3),
      .diff    (back_diff_ff),
      .gain    (back_gain_ff),
      .speed   (back_speed)
   );

   // Result transaction
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_data.tick_count  = s3_ff.tick_count;
   assign rsp_data.step_dir    = s3_ff.step_dir;
   assign rsp_data.bad_reading = s3_ff.bad_reading;
   assign rsp_data.front_speed = front_speed;
   assign rsp_data.back_speed  = back_speed;

endmodule

`default_nettype wire

// File: hw/rtl/zsds_checker.sv
// Port-level checks for the zone sensor decoder, bound to the top level.
// Depends on zsds_pkg and zone_sensor_decoder_speedometer_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "zone_sensor_decoder_speedometer_defines.svh"

module zsds_port_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire zsds_pkg::rsp_type rsp_data
);

   logic [31:0] last_tick_ff;
   logic [31:0] expect_tick;
   logic        dir_known;
   logic        rsp_stall;

   // Tick count of the previous result transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         last_tick_ff <= '0;
      end else if (rsp_valid && rsp_ready) begin
         last_tick_ff <= rsp_data.tick_count;
      end
   end

   always_comb begin
      case (rsp_data.step_dir)
         zsds_pkg::DIR_FWD:  expect_tick = last_tick_ff + 32'd1;
         zsds_pkg::DIR_BACK: expect_tick = last_tick_ff - 32'd1;
         default:            expect_tick = last_tick_ff;
      endcase
   end

   // Direction is one of the three defined codes
   assign dir_known = (rsp_data.step_dir == zsds_pkg::DIR_NONE)
                   || (rsp_data.step_dir == zsds_pkg::DIR_FWD)
                   || (rsp_data.step_dir == zsds_pkg::DIR_BACK);
   assign rsp_stall = rsp_valid && !rsp_ready;

   `ZSDS_ASSERT_NEXT(a_reset_clears_valid, clock, 1'b0, reset, !rsp_valid)
   `ZSDS_ASSERT_NEXT(a_stall_holds, clock, reset, rsp_stall, rsp_valid && $stable(rsp_data))
   `ZSDS_ASSERT_SAME(a_dir_code, clock, reset, rsp_valid, dir_known)
   `ZSDS_ASSERT_SAME(a_tick_follows_dir, clock, reset, rsp_valid, rsp_data.tick_count == expect_tick)

endmodule

bind zone_sensor_decoder_speedometer zsds_port_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
